@@ hdl/sstl_pkg.sv @@
package sstl_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int VALUE_BITS_DEF = 32;

    localparam int FIELD_W  = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int HELD_W   = 7;

    localparam int DIV_STEP = 4;
    localparam int DIVISOR  = 10;
    localparam int REM_W    = 4;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FEW   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic                capture;
        logic                ins_init;
        logic                ins_read;
        logic                ins_shift;
        logic                ins_place;
        logic                div_start;
        logic                div_sel;
        logic                div_take_first;
        logic                div_take_last;
        logic                srch_init;
        logic                srch_read;
        logic                srch_step;
        logic                y_read;
        logic                run_clear;
        logic                set_res;
        logic                res_hit;
        logic [STATUS_W-1:0] res_status;
        logic                emit;
    } sstl_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              few;
        logic              below;
        logic              above;
        logic              pos_zero;
        logic              rd_gt;
        logic              srch_done;
        logic              div_done;
        logic              out_free;
    } sstl_sts_t;

endpackage

@@ hdl/sstl_div10.sv @@
module sstl_div10 #(
    parameter int W = 33
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic         done,
    output logic [W-1:0] quotient
);
    import sstl_pkg::*;

    localparam int NSTEPS = (W + DIV_STEP - 1) / DIV_STEP;
    localparam int PW     = NSTEPS * DIV_STEP;
    localparam int CW     = $clog2(NSTEPS + 1);
    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    logic [PW-1:0]       num_reg;
    logic [PW-1:0]       quo_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [REM_W-1:0]    rem_next;
    logic [DIV_STEP-1:0] bits_next;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    // DIV_STEP bits of long division by ten per cycle while busy
    always_comb
    begin
        logic [REM_W:0] trial;
        rem_next  = rem_reg;
        bits_next = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_next, num_reg[PW-1-i]};
            if (trial >= DIV_C)
            begin
                rem_next = REM_W'(trial - DIV_C);
                bits_next[DIV_STEP-1-i] = 1'b1;
            end
            else
            begin
                rem_next = trial[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NSTEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= PW'(dividend);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << DIV_STEP;
            quo_reg <= {quo_reg[PW-DIV_STEP-1:0], bits_next};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[W-1:0];

endmodule

@@ hdl/sstl_datapath.sv @@
module sstl_datapath #(
    parameter int MAX_POINTS = sstl_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = sstl_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sstl_pkg::sstl_cmd_t                  cmd,
    output sstl_pkg::sstl_sts_t                  sts,
    input  logic [sstl_pkg::FUNC_W-1:0]          func,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  point_x,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  point_y,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  query_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [sstl_pkg::FIELD_W-1:0]  step_value,
    output logic                                 discontinuity,
    output logic [sstl_pkg::STATUS_W-1:0]        status,
    output logic [sstl_pkg::HELD_W-1:0]          points_held
);
    import sstl_pkg::*;

    localparam int VB = VALUE_BITS;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = VB + 1;
    localparam int BW = VB + 2;
    localparam int MW = 2 * VB;

    logic [FUNC_W-1:0]     func_reg;
    logic signed [VB-1:0]  nx_reg;
    logic signed [VB-1:0]  ny_reg;
    logic signed [VB-1:0]  t_reg;

    logic [MW-1:0]         point_mem [MAX_POINTS];
    logic [MW-1:0]         rdata_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         pos_m1;

    logic signed [VB-1:0]  f0_reg;
    logic signed [VB-1:0]  f1_reg;
    logic signed [VB-1:0]  l0_reg;
    logic signed [VB-1:0]  l1_reg;
    logic signed [BW-1:0]  lo_reg;
    logic signed [BW-1:0]  hi_reg;

    logic [CW-1:0]         low_reg;
    logic [CW-1:0]         high_reg;
    logic [CW-1:0]         mid_reg;
    logic [CW:0]           mid_sum;
    logic [CW-1:0]         mid;
    logic [CW-1:0]         low_m1;

    logic signed [VB-1:0]  res_value_reg;
    logic                  res_disc_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic signed [VB-1:0]  prev_reg;

    logic signed [FIELD_W-1:0] out_value_reg;
    logic                      out_disc_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [HELD_W-1:0]         out_held_reg;
    logic                      out_valid_reg;

    logic signed [VB-1:0]  rx;
    logic signed [VB-1:0]  ry;
    logic signed [BW-1:0]  t_ext;
    logic signed [DW-1:0]  w_first;
    logic signed [DW-1:0]  w_last;
    logic [DW-1:0]         div_in;
    logic                  div_done;
    logic [DW-1:0]         quot;
    logic signed [BW-1:0]  q_ext;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [MW-1:0]         wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    assign rx      = signed'(rdata_reg[MW-1:VB]);
    assign ry      = signed'(rdata_reg[VB-1:0]);
    assign t_ext   = BW'(t_reg);
    assign pos_m1  = pos_reg - CW'(1);
    assign low_m1  = low_reg - CW'(1);
    assign mid_sum = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid     = mid_sum[CW:1];

    // interval widths, never negative in a sorted table
    assign w_first = DW'(f1_reg) - DW'(f0_reg);
    assign w_last  = DW'(l0_reg) - DW'(l1_reg);
    assign div_in  = cmd.div_sel ? unsigned'(w_last) : unsigned'(w_first);
    assign q_ext   = signed'(BW'(quot));

    sstl_div10 #(
        .W (DW)
    ) u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_in),
        .done     (div_done),
        .quotient (quot)
    );

    assign wr_en   = cmd.ins_shift | cmd.ins_place;
    assign wr_addr = pos_reg[AW-1:0];
    assign wr_data = cmd.ins_place ? {nx_reg, ny_reg} : rdata_reg;
    assign rd_en   = cmd.ins_read | cmd.srch_read | cmd.y_read;

    always_comb
    begin
        if (cmd.ins_read)
        begin
            rd_addr = pos_m1[AW-1:0];
        end
        else if (cmd.srch_read)
        begin
            rd_addr = mid[AW-1:0];
        end
        else
        begin
            rd_addr = low_m1[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            point_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= point_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins_place)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.run_clear)
            begin
                prev_reg <= '0;
            end
            else if (cmd.set_res && cmd.res_hit)
            begin
                prev_reg <= ry;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            nx_reg   <= VB'(point_x);
            ny_reg   <= VB'(point_y);
            t_reg    <= VB'(query_time);
        end
        if (cmd.ins_init)
        begin
            pos_reg <= count_reg;
        end
        else if (cmd.ins_shift)
        begin
            pos_reg <= pos_m1;
        end
        // first two and last two x follow each insert
        if (cmd.ins_place)
        begin
            if (pos_reg == '0)
            begin
                f0_reg <= nx_reg;
                f1_reg <= f0_reg;
            end
            else if (pos_reg == CW'(1))
            begin
                f1_reg <= nx_reg;
            end
            if (pos_reg == count_reg)
            begin
                l0_reg <= nx_reg;
                l1_reg <= l0_reg;
            end
            else if (pos_reg + CW'(1) == count_reg)
            begin
                l1_reg <= nx_reg;
            end
        end
        if (cmd.div_take_first)
        begin
            lo_reg <= BW'(f0_reg) - q_ext;
        end
        if (cmd.div_take_last)
        begin
            hi_reg <= BW'(l0_reg) + q_ext;
        end
        if (cmd.srch_init)
        begin
            low_reg  <= CW'(1);
            high_reg <= count_reg;
        end
        else if (cmd.srch_step)
        begin
            if (rx > t_reg)
            begin
                high_reg <= mid_reg;
            end
            else
            begin
                low_reg <= mid_reg + CW'(1);
            end
        end
        if (cmd.srch_read)
        begin
            mid_reg <= mid;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            if (cmd.res_hit)
            begin
                res_value_reg <= ry;
                res_disc_reg  <= (ry != prev_reg);
            end
            else
            begin
                res_value_reg <= '0;
                res_disc_reg  <= 1'b0;
            end
        end
        if (cmd.emit)
        begin
            out_value_reg  <= FIELD_W'(res_value_reg);
            out_disc_reg   <= res_disc_reg;
            out_status_reg <= res_status_reg;
            out_held_reg   <= HELD_W'(count_reg);
        end
    end

    assign sts.func      = func_reg;
    assign sts.full      = (count_reg == CW'(MAX_POINTS));
    assign sts.few       = (count_reg < CW'(2));
    assign sts.below     = (t_ext < lo_reg);
    assign sts.above     = (t_ext > hi_reg);
    assign sts.pos_zero  = (pos_reg == '0);
    assign sts.rd_gt     = (rx > nx_reg);
    assign sts.srch_done = (low_reg >= high_reg);
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign step_value    = out_value_reg;
    assign discontinuity = out_disc_reg;
    assign status        = out_status_reg;
    assign points_held   = out_held_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS))
        else $error("point count above capacity");

    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_place |-> !sts.full)
        else $error("insert into full table");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != ST_OK) |->
            (out_value_reg == '0) && !out_disc_reg)
        else $error("failed request carries a value");

    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_held_reg == HELD_W'($past(count_reg)))
        else $error("points held does not match table");
`endif

endmodule

@@ hdl/sstl_ctrl.sv @@
module sstl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sstl_pkg::sstl_sts_t sts,
    output sstl_pkg::sstl_cmd_t cmd
);
    import sstl_pkg::*;

    typedef enum logic [3:0] {
        IDLE,
        DECODE,
        INS_TEST,
        INS_CMP,
        BOUNDS,
        DIV_FIRST,
        DIV_LAST,
        SRCH_TEST,
        SRCH_CMP,
        Y_WAIT,
        EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = DECODE;
                end
            end
            DECODE:
            begin
                unique case (sts.func)
                    FUNC_LOAD:
                    begin
                        if (sts.full)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_FULL;
                            state_next     = EMIT;
                        end
                        else
                        begin
                            cmd.ins_init = 1'b1;
                            state_next   = INS_TEST;
                        end
                    end
                    FUNC_RUN:
                    begin
                        cmd.run_clear  = 1'b1;
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = EMIT;
                    end
                    FUNC_QUERY:
                    begin
                        if (sts.few)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_FEW;
                            state_next     = EMIT;
                        end
                        else if (sts.below)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_BELOW;
                            state_next     = EMIT;
                        end
                        else if (sts.above)
                        begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_ABOVE;
                            state_next     = EMIT;
                        end
                        else
                        begin
                            cmd.srch_init = 1'b1;
                            state_next    = SRCH_TEST;
                        end
                    end
                    default:
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = ST_OK;
                        state_next     = EMIT;
                    end
                endcase
            end
            INS_TEST:
            begin
                if (sts.pos_zero)
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = BOUNDS;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = INS_CMP;
                end
            end
            INS_CMP:
            begin
                if (sts.rd_gt)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = INS_TEST;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                    state_next    = BOUNDS;
                end
            end
            BOUNDS:
            begin
                if (sts.few)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = EMIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIV_FIRST;
                end
            end
            DIV_FIRST:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take_first = 1'b1;
                    cmd.div_start      = 1'b1;
                    cmd.div_sel        = 1'b1;
                    state_next         = DIV_LAST;
                end
            end
            DIV_LAST:
            begin
                if (sts.div_done)
                begin
                    cmd.div_take_last = 1'b1;
                    cmd.set_res       = 1'b1;
                    cmd.res_status    = ST_OK;
                    state_next        = EMIT;
                end
            end
            SRCH_TEST:
            begin
                if (sts.srch_done)
                begin
                    cmd.y_read = 1'b1;
                    state_next = Y_WAIT;
                end
                else
                begin
                    cmd.srch_read = 1'b1;
                    state_next    = SRCH_CMP;
                end
            end
            SRCH_CMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = SRCH_TEST;
            end
            Y_WAIT:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_hit    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = EMIT;
            end
            EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != IDLE);

endmodule

@@ hdl/sorted_step_table_lookup_core.sv @@
// per request: a query runs a binary search (one memory read per probe); a load shifts
// each larger entry up one place, then the divide-by-ten unit sizes the range
// one request in flight; the next is taken while a finished result waits at the output
// reset is asynchronous active low: empty table, last value zero, no result pending
// table contents are not cleared; entries at or above the point count are never read
module sorted_step_table_lookup_core #(
    parameter int MAX_POINTS = sstl_pkg::MAX_POINTS_DEF,
    parameter int VALUE_BITS = sstl_pkg::VALUE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sstl_pkg::FUNC_W-1:0]          func,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  point_x,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  point_y,
    input  logic signed [sstl_pkg::FIELD_W-1:0]  query_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [sstl_pkg::FIELD_W-1:0]  step_value,
    output logic                                 discontinuity,
    output logic [sstl_pkg::STATUS_W-1:0]        status,
    output logic [sstl_pkg::HELD_W-1:0]          points_held
);
    import sstl_pkg::*;

    sstl_cmd_t cmd;
    sstl_sts_t sts;

    sstl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sstl_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .point_x       (point_x),
        .point_y       (point_y),
        .query_time    (query_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .step_value    (step_value),
        .discontinuity (discontinuity),
        .status        (status),
        .points_held   (points_held)
    );

endmodule
